// ===== sv/msv_pkg.sv =====
// Shared constants, types and constant tables of the sine voice.
package msv_pkg;

  // Build-time settings
  localparam int unsigned SineTableDepth = 1024;   // power of two, 256..16384
  localparam int unsigned SampleRate     = 44100;

  localparam int unsigned SineIdxW  = $clog2(SineTableDepth);
  localparam int unsigned SineAddrW = SineIdxW - 1;
  localparam int unsigned SineHalf  = SineTableDepth / 2;

  // Field widths
  localparam int unsigned PhaseW   = 32;
  localparam int unsigned EnvW     = 25;
  localparam int unsigned EnvFracW = 24;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned VelW     = 7;
  localparam int unsigned StatusW  = 8;
  localparam int unsigned SineMagW = 15;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned NoteCount = 1 << NoteW;

  // Serial datapath widths
  localparam int unsigned MagW      = SineMagW + VelW;            // |sine| * velocity
  localparam int unsigned ProdHiW   = MagW + EnvW - EnvFracW;     // product >> 24
  localparam int unsigned DivW      = ProdHiW;
  localparam int unsigned RemW      = 8;
  localparam int unsigned MulCntW   = $clog2(EnvW);
  localparam int unsigned DivCntW   = $clog2(DivW);

  localparam logic [EnvW-1:0] EnvUnity    = {1'b1, {EnvFracW{1'b0}}};
  localparam logic [EnvW-1:0] StepReset   = EnvW'(38044);
  localparam logic [RemW-1:0] VelDen      = RemW'(254);
  localparam logic [RemW-1:0] RoundBias   = RemW'(127);

  // Codes
  localparam logic        CmdTick       = 1'b1;
  localparam logic [3:0]  StatusNoteOn  = 4'h9;
  localparam logic [3:0]  StatusNoteOff = 4'h8;
  localparam logic [CfgIdxW-1:0] CfgAttack  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRelease = CfgIdxW'(1);

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StMul,
    StDiv,
    StDone
  } msv_state_e;

  // Angle constants, Q30 radians
  localparam logic [63:0] PiQ30     = 64'd3373259426;
  localparam logic [63:0] TwoPiQ30  = 64'd6746518852;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic [63:0] taylor_div_t [6];
  localparam taylor_div_t TaylorDiv = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef logic [31:0] note_base_t [12];
  localparam note_base_t NoteBaseQ28 = '{
    32'd2194674310, 32'd2325176436, 32'd2463438621, 32'd2609922305,
    32'd2765116361, 32'd2929538736, 32'd3103738174, 32'd3288296050,
    32'd3483828309, 32'd3690987520, 32'd3910465059, 32'd4142993412
  };

  typedef logic [SineMagW-1:0] sine_tab_t [SineHalf];
  typedef logic [PhaseW-1:0]   note_step_tab_t [NoteCount];

  // Magnitude of sine for a table index in the first half turn
  function automatic logic [SineMagW-1:0] sine_mag(input logic [63:0] idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    x = (TwoPiQ30 * idx) / SineTableDepth;
    if (x > HalfPiQ30) x = PiQ30 - x;
    x2 = (x * x) >> 30;
    t  = x;
    s  = x;
    for (int k = 0; k < 6; k++) begin
      t = ((t * x2) >> 30) / TaylorDiv[k];
      if ((k & 1) == 0) s = s - t;
      else s = s + t;
    end
    q = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) q = 64'd32767;
    return q[SineMagW-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int unsigned i = 0; i < SineHalf; i++) tab[i] = sine_mag(64'(i));
    return tab;
  endfunction

  function automatic note_step_tab_t build_note_steps();
    note_step_tab_t tab;
    logic [63:0] f;
    logic [63:0] st;
    for (int unsigned n = 0; n < NoteCount; n++) begin
      f  = {32'd0, NoteBaseQ28[n % 12]} << (n / 12 + 4);
      st = (f + 64'(SampleRate / 2)) / SampleRate;
      tab[n] = st[PhaseW-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t      SineTab   = build_sine_tab();
  localparam note_step_tab_t NoteSteps = build_note_steps();

endpackage

// ===== sv/msv_if.sv =====
// Valid/ready channel interfaces: MIDI/tick input, sample output, register writes.
interface msv_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [msv_pkg::StatusW-1:0]   status_byte;
  logic [msv_pkg::NoteW-1:0]     data_one;
  logic [msv_pkg::VelW-1:0]      data_two;

  modport source (output valid, command, status_byte, data_one, data_two, input ready);
  modport sink   (input valid, command, status_byte, data_one, data_two, output ready);
endinterface

interface msv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [msv_pkg::SampleW-1:0] sample;
  logic                               sounding;

  modport source (output valid, sample, sounding, input ready);
  modport sink   (input valid, sample, sounding, output ready);
endinterface

interface msv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [msv_pkg::CfgIdxW-1:0]   index;
  logic [msv_pkg::EnvW-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/midi_sine_voice_with_envelope.sv =====
// Top level of the monophonic MIDI sine voice with linear attack/release envelope.
//
// Monophonic sine voice. Each request on in_i is either a MIDI message
// (command 0) or one sample tick (command 1). Note-on (status 9n, velocity
// above zero) latches note and velocity, loads the phase step from a note
// table and starts the attack; note-off (8n, or 9n with velocity zero) for
// the held note starts the release. Every tick yields exactly one request on
// out_o: a Q15 sample of sine(phase) * velocity / 254 * envelope, rounded to
// nearest with ties away from zero, plus a sounding flag; silent ticks give
// sample 0, sounding 0. Attack and release steps are written on cfg_i
// (index 0 attack, 1 release, unity = 2^24); the user must write them only
// while the voice is idle; the block does not enforce it. MIDI messages are
// taken without leaving the idle state; a silent tick goes straight to the
// output hand-over; a sounding tick holds in_i.ready low through a sine ROM
// read, the bit-serial multiplier (one envelope bit a cycle), the bit-serial
// divider by 254 (one quotient bit a cycle) and the hand-over to the output
// register. in_i is taken again as soon as the result sits there, even if
// out_o has not yet been drained; a further tick then waits for the slot.
module midi_sine_voice_with_envelope (
  input  logic        clk_i,
  input  logic        rst_ni,
  msv_in_if.sink      in_i,
  msv_out_if.source   out_o,
  msv_cfg_if.sink     cfg_i
);

  // ---------------------------------------------------------------- state
  msv_pkg::msv_state_e               state_q, state_d;

  logic [msv_pkg::EnvW-1:0]          attack_q, attack_d;
  logic [msv_pkg::EnvW-1:0]          release_q, release_d;
  logic [msv_pkg::PhaseW-1:0]        phase_acc_q, phase_acc_d;
  logic [msv_pkg::PhaseW-1:0]        phase_step_q, phase_step_d;
  logic [msv_pkg::NoteW-1:0]         held_note_q, held_note_d;
  logic [msv_pkg::VelW-1:0]          held_vel_q, held_vel_d;
  logic [msv_pkg::EnvW-1:0]          env_q, env_d;
  logic                              env_rising_q, env_rising_d;
  logic                              silent_q, silent_d;
  logic                              out_valid_q, out_valid_d;

  // payload registers
  logic                              neg_q;
  logic signed [msv_pkg::SampleW-1:0] sample_q;
  logic                              sounding_q;

  // ---------------------------------------------------------------- handshakes
  logic in_rdy;
  logic in_acc;
  logic cfg_acc;
  logic is_tick;
  logic tick_silent;
  logic mul_start;
  logic div_start;
  logic out_load;

  assign in_acc  = in_i.valid && in_rdy;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign is_tick = in_i.command == msv_pkg::CmdTick;

  // silent: no note held and envelope fully down
  assign tick_silent = (held_note_q == '0) && (env_q == '0);

  // ---------------------------------------------------------------- MIDI decode
  logic [3:0] status_hi;
  logic       note_on;
  logic       note_off;

  assign status_hi = in_i.status_byte[msv_pkg::StatusW-1 -: 4];
  assign note_on   = (status_hi == msv_pkg::StatusNoteOn) && (in_i.data_two != '0);
  // note-on with zero velocity counts as note-off
  assign note_off  = !note_on && ((status_hi == msv_pkg::StatusNoteOff) ||
                                  (status_hi == msv_pkg::StatusNoteOn));

  // ---------------------------------------------------------------- envelope step
  logic [msv_pkg::EnvW:0]   env_sum;
  logic [msv_pkg::EnvW-1:0] env_up;
  logic [msv_pkg::EnvW-1:0] env_dn;

  assign env_sum = {1'b0, env_q} + {1'b0, attack_q};
  assign env_up  = (env_sum >= {1'b0, msv_pkg::EnvUnity}) ? msv_pkg::EnvUnity
                                                          : env_sum[msv_pkg::EnvW-1:0];
  assign env_dn  = (env_q > release_q) ? (env_q - release_q) : '0;

  // ---------------------------------------------------------------- datapath units
  logic                           rom_neg;
  logic [msv_pkg::SineMagW-1:0]   rom_mag;
  logic [msv_pkg::MagW-1:0]       mcand;
  logic                           mul_done;
  logic [msv_pkg::ProdHiW-1:0]    prod_hi;
  logic [msv_pkg::DivW-1:0]       dividend;
  logic                           div_done;
  logic [msv_pkg::DivW-1:0]       quot;
  logic [msv_pkg::SampleW-1:0]    q_mag;
  logic [msv_pkg::SampleW-1:0]    q_signed;

  // ROM samples the phase before the tick's advance: it reads on the
  // accepting edge, when phase_acc_q still holds the old value
  msv_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (phase_acc_q[msv_pkg::PhaseW-1 -: msv_pkg::SineIdxW]),
    .neg_o  (rom_neg),
    .mag_o  (rom_mag)
  );

  assign mcand = msv_pkg::MagW'(rom_mag) * msv_pkg::MagW'(held_vel_q);

  // |sine| * velocity * envelope, top bits only (the 2^24 of the divisor)
  msv_serial_mul u_serial_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mcand),
    .mplier_i  (env_q),
    .done_o    (mul_done),
    .prod_hi_o (prod_hi)
  );

  // half the divisor added before the divide gives round half up
  assign dividend = msv_pkg::DivW'(prod_hi) + msv_pkg::DivW'(msv_pkg::RoundBias);

  msv_serial_div u_serial_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign q_mag    = quot[msv_pkg::SampleW-1:0];
  assign q_signed = neg_q ? (~q_mag + 1'b1) : q_mag;

  // ---------------------------------------------------------------- FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      msv_pkg::StIdle: begin
        if (in_acc && is_tick) begin
          state_d = tick_silent ? msv_pkg::StDone : msv_pkg::StLoad;
        end
      end
      msv_pkg::StLoad: state_d = msv_pkg::StMul;
      msv_pkg::StMul: begin
        if (mul_done) state_d = msv_pkg::StDiv;
      end
      msv_pkg::StDiv: begin
        if (div_done) state_d = msv_pkg::StDone;
      end
      msv_pkg::StDone: begin
        if (!out_valid_q || out_o.ready) state_d = msv_pkg::StIdle;
      end
      default: state_d = msv_pkg::StIdle;
    endcase
  end

  // ---------------------------------------------------------------- FSM outputs
  always_comb begin
    in_rdy    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      msv_pkg::StIdle: in_rdy = 1'b1;
      msv_pkg::StLoad: mul_start = 1'b1;
      msv_pkg::StMul:  div_start = mul_done;
      msv_pkg::StDiv:  ;
      msv_pkg::StDone: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- voice state update
  always_comb begin
    attack_d     = attack_q;
    release_d    = release_q;
    phase_acc_d  = phase_acc_q;
    phase_step_d = phase_step_q;
    held_note_d  = held_note_q;
    held_vel_d   = held_vel_q;
    env_d        = env_q;
    env_rising_d = env_rising_q;
    silent_d     = silent_q;

    if (cfg_acc) begin
      case (cfg_i.index)
        msv_pkg::CfgAttack:  attack_d  = cfg_i.data;
        msv_pkg::CfgRelease: release_d = cfg_i.data;
        default: ;
      endcase
    end

    if (in_acc) begin
      if (!is_tick) begin
        if (note_on) begin
          held_note_d  = in_i.data_one;
          held_vel_d   = in_i.data_two;
          phase_step_d = msv_pkg::NoteSteps[in_i.data_one];
          env_rising_d = 1'b1;
        end else if (note_off && (held_note_q == in_i.data_one)) begin
          held_note_d  = '0;
          env_rising_d = 1'b0;
        end
      end else begin
        silent_d = tick_silent;
        if (!tick_silent) begin
          // envelope steps before the multiply; phase advances after the ROM read
          env_d       = env_rising_q ? env_up : env_dn;
          phase_acc_d = phase_acc_q + phase_step_q;
        end
      end
    end
  end

  // ---------------------------------------------------------------- output slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= msv_pkg::StIdle;
      attack_q     <= msv_pkg::StepReset;
      release_q    <= msv_pkg::StepReset;
      phase_acc_q  <= '0;
      phase_step_q <= '0;
      held_note_q  <= '0;
      held_vel_q   <= '0;
      env_q        <= '0;
      env_rising_q <= 1'b0;
      silent_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      attack_q     <= attack_d;
      release_q    <= release_d;
      phase_acc_q  <= phase_acc_d;
      phase_step_q <= phase_step_d;
      held_note_q  <= held_note_d;
      held_vel_q   <= held_vel_d;
      env_q        <= env_d;
      env_rising_q <= env_rising_d;
      silent_q     <= silent_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // sign captured alongside the multiply start, while the ROM still shows this tick
  always_ff @(posedge clk_i) begin
    if (mul_start) neg_q <= rom_neg;
    if (out_load) begin
      sample_q   <= silent_q ? '0 : $signed(q_signed);
      sounding_q <= !silent_q;
    end
  end

  assign in_i.ready     = in_rdy;
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.sample   = sample_q;
  assign out_o.sounding = sounding_q;

endmodule

// ===== sv/msv_sine_rom.sv =====
// Half-wave sine magnitude ROM with registered read and sign from the index MSB.
module msv_sine_rom (
  input  logic                           clk_i,
  input  logic [msv_pkg::SineIdxW-1:0]   addr_i,
  output logic                           neg_o,
  output logic [msv_pkg::SineMagW-1:0]   mag_o
);

  logic                         neg_q;
  logic [msv_pkg::SineMagW-1:0] mag_q;

  // second half turn is the first one negated
  always_ff @(posedge clk_i) begin
    mag_q <= msv_pkg::SineTab[addr_i[msv_pkg::SineAddrW-1:0]];
    neg_q <= addr_i[msv_pkg::SineIdxW-1];
  end

  assign neg_o = neg_q;
  assign mag_o = mag_q;

endmodule

// ===== sv/msv_serial_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, keeps product >> 24.
module msv_serial_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [msv_pkg::MagW-1:0]      mcand_i,
  input  logic [msv_pkg::EnvW-1:0]      mplier_i,
  output logic                          done_o,
  output logic [msv_pkg::ProdHiW-1:0]   prod_hi_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [msv_pkg::MulCntW-1:0]   cnt_q, cnt_d;
  logic [msv_pkg::MagW-1:0]      acc_q, acc_d;
  logic [msv_pkg::EnvW-1:0]      mpl_q, mpl_d;
  logic [msv_pkg::MagW-1:0]      mcand_q, mcand_d;
  logic [msv_pkg::MagW:0]        sum;

  assign sum = {1'b0, acc_q} + (mpl_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    mpl_d   = mpl_q;
    mcand_d = mcand_q;
    if (start_i) begin
      busy_d  = 1'b1;
      done_d  = 1'b0;
      cnt_d   = '0;
      acc_d   = '0;
      mpl_d   = mplier_i;
      mcand_d = mcand_i;
    end else if (busy_q) begin
      // low product bits shift into the multiplier register
      acc_d = sum[msv_pkg::MagW:1];
      mpl_d = {sum[0], mpl_q[msv_pkg::EnvW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == msv_pkg::MulCntW'(msv_pkg::EnvW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mpl_q   <= mpl_d;
    mcand_q <= mcand_d;
  end

  assign done_o    = done_q;
  assign prod_hi_o = {acc_q, mpl_q[msv_pkg::EnvW-1]};

endmodule

// ===== sv/msv_serial_div.sv =====
// Restoring divider by 254, one quotient bit per cycle.
module msv_serial_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [msv_pkg::DivW-1:0]    dividend_i,
  output logic                        done_o,
  output logic [msv_pkg::DivW-1:0]    quot_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [msv_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [msv_pkg::RemW-1:0]      rem_q, rem_d;
  logic [msv_pkg::DivW-1:0]      quo_q, quo_d;
  logic [msv_pkg::RemW:0]        trial;
  logic [msv_pkg::RemW:0]        diff;
  logic                          ge;

  assign trial = {rem_q, quo_q[msv_pkg::DivW-1]};
  assign ge    = trial >= {1'b0, msv_pkg::VelDen};
  assign diff  = trial - {1'b0, msv_pkg::VelDen};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // remainder stays below 254, so eight bits hold it either way
      rem_d = ge ? diff[msv_pkg::RemW-1:0] : trial[msv_pkg::RemW-1:0];
      quo_d = {quo_q[msv_pkg::DivW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == msv_pkg::DivCntW'(msv_pkg::DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/msv_checker.sv =====
// Port-level checker for the sine voice, bound to the top level.
module msv_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_command_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [msv_pkg::SampleW-1:0]   out_sample_i,
  input logic                          out_sounding_i
);

  // a tick always occupies the voice for at least the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_command_i == msv_pkg::CmdTick)) |=> !in_ready_i)
    else $error("input still ready after tick request");

  // the input is ready again in the cycle after a MIDI message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_command_i != msv_pkg::CmdTick)) |=> in_ready_i)
    else $error("input not ready after MIDI request");

  // silent results carry a zero sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_sounding_i) |-> (out_sample_i == '0))
    else $error("non-zero sample while not sounding");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_sample_i) && $stable(out_sounding_i)))
    else $error("stalled result changed");

endmodule

bind midi_sine_voice_with_envelope msv_checker u_msv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_command_i   (in_i.command),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_sample_i   (out_o.sample),
  .out_sounding_i (out_o.sounding)
);
